// ===== sv/pat_pkg.sv =====
// ----------------------------------------------------------------------------
// pat_pkg
// Shared types and codes for the peer association table.
// ----------------------------------------------------------------------------
package pat_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    STS_HIT     = 3'd0,
    STS_NEW     = 3'd1,
    STS_REUSED  = 3'd2,
    STS_FULL    = 3'd3,
    STS_BADADDR = 3'd4,
    STS_SWEPT   = 3'd5
  } status_t;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_SWEEP  = 1'b1;

  localparam logic REG_LIFETIME = 1'b0;

  localparam logic [15:0] LIFETIME_RESET = 16'd60;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] expiry;
  } slot_entry_t;

  typedef struct packed {
    logic        occupied;
    slot_entry_t entry;
  } slot_rd_t;

endpackage

// ===== sv/pat_slot_mem.sv =====
// ----------------------------------------------------------------------------
// pat_slot_mem
// Slot store: one synchronous memory of address and expiry, registered read,
// plus one occupied bit per slot cleared at reset.
// ----------------------------------------------------------------------------
module pat_slot_mem #(
  parameter int DEPTH = 8,
  parameter int IDX_W = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_idx,
  output pat_pkg::slot_rd_t   rd_data,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_idx,
  input  pat_pkg::slot_entry_t wr_entry,
  input  logic                clr_en,
  input  logic [IDX_W-1:0]    clr_idx
);
  import pat_pkg::*;

  slot_entry_t      mem_r [DEPTH];
  slot_entry_t      rd_entry_r;
  logic             rd_occ_r;
  logic [DEPTH-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry_r <= mem_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_occ_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (clr_en) begin
        valid_r[clr_idx] <= 1'b0;
      end
      if (rd_en) begin
        rd_occ_r <= valid_r[rd_idx];
      end
    end
  end

  assign rd_data.occupied = rd_occ_r;
  assign rd_data.entry    = rd_entry_r;

endmodule

// ===== sv/pat_ctrl.sv =====
// ----------------------------------------------------------------------------
// pat_ctrl
// Scan sequencer: walks the slot store per item, gathers hit, free and expired
// candidates (sweeps clear expired ones), writes any claim, issues the result.
// ----------------------------------------------------------------------------
module pat_ctrl #(
  parameter int PEER_SLOTS = 8,
  parameter int IDX_W      = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [31:0]          in_peer_addr,
  input  logic [31:0]          in_now_ms,
  input  logic [15:0]          lifetime,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [5:0]           out_slot_index,
  output logic [2:0]           out_status,
  output logic [6:0]           out_freed_count,
  output logic                 rd_en,
  output logic [IDX_W-1:0]     rd_idx,
  input  pat_pkg::slot_rd_t    rd_data,
  output logic                 wr_en,
  output logic [IDX_W-1:0]     wr_idx,
  output pat_pkg::slot_entry_t wr_entry,
  output logic                 clr_en,
  output logic [IDX_W-1:0]     clr_idx
);
  import pat_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PEER_SLOTS - 1);

  state_t           state_r, state_nxt;
  logic             cmd_r;
  logic [31:0]      addr_r;
  logic [31:0]      now_r;
  logic             bad_r;
  logic [IDX_W-1:0] eval_idx_r;
  logic             hit_found_r, free_found_r, exp_found_r;
  logic [IDX_W-1:0] hit_idx_r, free_idx_r, exp_idx_r;
  logic [6:0]       freed_r;

  logic             out_valid_r;
  logic [5:0]       out_slot_r;
  status_t          out_status_r;
  logic [6:0]       out_freed_r;

  logic             in_accept;
  logic             out_free;
  logic [31:0]      diff;
  logic             expired;
  logic             hit;
  logic             claim;
  logic [IDX_W-1:0] res_idx;
  status_t          res_status;
  logic [5:0]       res_slot;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  assign diff    = now_r - {rd_data.entry.expiry, 16'h0000};
  assign expired = !diff[31];
  assign hit     = rd_data.occupied && (rd_data.entry.addr == addr_r);

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_idx    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          rd_en = 1'b1;
          if (in_cmd == CMD_LOOKUP && in_peer_addr == 32'h0) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (eval_idx_r == LAST_IDX) begin
          state_nxt = S_FIN;
        end else begin
          rd_en  = 1'b1;
          rd_idx = eval_idx_r + IDX_W'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign clr_en  = (state_r == S_SCAN) && (cmd_r == CMD_SWEEP) && rd_data.occupied && expired;
  assign clr_idx = eval_idx_r;

  always_comb begin
    res_idx    = '0;
    res_status = STS_FULL;
    claim      = 1'b0;
    priority if (cmd_r == CMD_SWEEP) begin
      res_status = STS_SWEPT;
    end else if (bad_r) begin
      res_status = STS_BADADDR;
    end else if (hit_found_r) begin
      res_idx    = hit_idx_r;
      res_status = STS_HIT;
    end else if (free_found_r) begin
      res_idx    = free_idx_r;
      res_status = STS_NEW;
      claim      = 1'b1;
    end else if (exp_found_r) begin
      res_idx    = exp_idx_r;
      res_status = STS_REUSED;
      claim      = 1'b1;
    end else begin
      res_status = STS_FULL;
    end
  end

  assign res_slot        = 6'(res_idx);
  assign wr_en           = (state_r == S_FIN) && out_free && claim;
  assign wr_idx          = res_idx;
  assign wr_entry.addr   = addr_r;
  assign wr_entry.expiry = now_r[31:16] + lifetime;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r        <= in_cmd;
      addr_r       <= in_peer_addr;
      now_r        <= in_now_ms;
      bad_r        <= (in_cmd == CMD_LOOKUP) && (in_peer_addr == 32'h0);
      eval_idx_r   <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      exp_found_r  <= 1'b0;
      freed_r      <= '0;
    end else if (state_r == S_SCAN) begin
      eval_idx_r <= eval_idx_r + IDX_W'(1);
      if (clr_en) begin
        freed_r <= freed_r + 7'd1;
      end
      if (cmd_r == CMD_LOOKUP) begin
        if (hit && !hit_found_r) begin
          hit_found_r <= 1'b1;
          hit_idx_r   <= eval_idx_r;
        end
        if (!rd_data.occupied && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= eval_idx_r;
        end
        if (expired && !exp_found_r) begin
          exp_found_r <= 1'b1;
          exp_idx_r   <= eval_idx_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_slot_r   <= res_slot;
      out_status_r <= res_status;
      out_freed_r  <= (cmd_r == CMD_SWEEP) ? freed_r : 7'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slot_index  = out_slot_r;
  assign out_status      = out_status_r;
  assign out_freed_count = out_freed_r;

  a_wr_only_fin: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_FIN) && (cmd_r == CMD_LOOKUP) && !bad_r && !hit_found_r)
    else $error("slot write outside lookup finish");

  a_clr_only_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clr_en |-> (state_r == S_SCAN) && (cmd_r == CMD_SWEEP))
    else $error("slot clear outside sweep scan");

  a_freed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (freed_r <= 7'(PEER_SLOTS)))
    else $error("freed count exceeds slot count");

  a_scan_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_accept)
    else $error("item accepted while busy");

endmodule

// ===== sv/peer_association_table.sv =====
// ----------------------------------------------------------------------------
// peer_association_table
// Peer slot table with lookup/allocate and expiry sweep, APB-style config.
// ----------------------------------------------------------------------------
// Each item runs from acceptance, which issues the first read, through a scan
// of each slot in turn through the single read port of the slot memory, to a
// finish step for the write-back and result; a lookup of address zero skips
// the scan. No new item is accepted until the finish step is left. Results
// wait in an output register; while an earlier result is still held there
// by out_stall, the finish step repeats and the next acceptance waits too.
// Slot occupancy is kept in flip-flops cleared by reset, so no clearing pass
// is needed after reset.
module peer_association_table #(
  parameter int PEER_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [31:0] in_peer_addr,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_slot_index,
  output logic [2:0]  out_status,
  output logic [6:0]  out_freed_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pat_pkg::*;

  localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

  logic [15:0]      lifetime_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  slot_rd_t         rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  slot_entry_t      wr_entry;
  logic             clr_en;
  logic [IDX_W-1:0] clr_idx;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= LIFETIME_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LIFETIME) begin
      lifetime_r <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_LIFETIME) ? {16'h0000, lifetime_r} : 32'h0;

  pat_ctrl #(
    .PEER_SLOTS (PEER_SLOTS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_peer_addr    (in_peer_addr),
    .in_now_ms       (in_now_ms),
    .lifetime        (lifetime_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_slot_index  (out_slot_index),
    .out_status      (out_status),
    .out_freed_count (out_freed_count),
    .rd_en           (rd_en),
    .rd_idx          (rd_idx),
    .rd_data         (rd_data),
    .wr_en           (wr_en),
    .wr_idx          (wr_idx),
    .wr_entry        (wr_entry),
    .clr_en          (clr_en),
    .clr_idx         (clr_idx)
  );

  pat_slot_mem #(
    .DEPTH (PEER_SLOTS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_entry (wr_entry),
    .clr_en   (clr_en),
    .clr_idx  (clr_idx)
  );

endmodule
